@@ rtl/core/tdma_ring_phase_observer_core_defines.svh @@
// ---------------------------------------------------------------------------
// TDMA ring phase observer assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef TDMA_RING_PHASE_OBSERVER_CORE_DEFINES_SVH
`define TDMA_RING_PHASE_OBSERVER_CORE_DEFINES_SVH
`ifndef SYNTH
// check while out of reset
`define TRPO_ASSERT(lbl, prop) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    prop) else $error("trpo assertion failed");
// check that also spans reset
`define TRPO_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge i_clk) \
    prop) else $error("trpo reset assertion failed");
`else
`define TRPO_ASSERT(lbl, prop)
`define TRPO_ASSERT_RST(lbl, prop)
`endif
`endif

@@ rtl/core/trpo_pkg.sv @@
// ---------------------------------------------------------------------------
// TDMA ring phase observer package
// Constants, register indexes and the stage record of the remainder chain.
// ---------------------------------------------------------------------------
package trpo_pkg;

    localparam int MAX_NODES           = 16;
    localparam int RESOLUTION_LIMIT_NS = 100;
    localparam int NUM_CELLS           = 64;

    // register indexes
    localparam logic [3:0] REG_SCHEDULE_ENABLED  = 4'd0;
    localparam logic [3:0] REG_PERIOD_NS         = 4'd1;
    localparam logic [3:0] REG_WINDOW_OFFSET_NS  = 4'd2;
    localparam logic [3:0] REG_WINDOW_WIDTH_NS   = 4'd3;
    localparam logic [3:0] REG_RING_NODES        = 4'd4;
    localparam logic [3:0] REG_LOCAL_SLOT        = 4'd5;
    localparam logic [3:0] REG_REFERENCE_SLOT    = 4'd6;
    localparam logic [3:0] REG_SCHEDULE_CHECKSUM = 4'd7;

    // one request traveling down the remainder chain
    typedef struct packed {
        logic        vld;
        logic        ok;
        logic [31:0] tx;
        logic [31:0] rx;
        logic [63:0] common;
        logic [31:0] rem_a;
        logic [63:0] div_a;
        logic [31:0] rem_b;
        logic [63:0] div_b;
    } t_stage;

endpackage

@@ rtl/core/trpo_cell.sv @@
// ---------------------------------------------------------------------------
// TDMA ring phase observer remainder cell
// One restoring-division step for two remainder lanes, registered.
// ---------------------------------------------------------------------------
module trpo_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [31:0]     i_period,
    input  trpo_pkg::t_stage i_prev,
    output trpo_pkg::t_stage o_next
);
    import trpo_pkg::*;

    logic [32:0] w_ta;
    logic [32:0] w_tb;
    t_stage      n_st;
    t_stage      r_st;

    // shift in next dividend bit and subtract period when it fits
    always_comb begin
        w_ta = {i_prev.rem_a, i_prev.div_a[63]};
        w_tb = {i_prev.rem_b, i_prev.div_b[63]};
        if (w_ta >= {1'b0, i_period}) begin
            w_ta = w_ta - {1'b0, i_period};
        end
        if (w_tb >= {1'b0, i_period}) begin
            w_tb = w_tb - {1'b0, i_period};
        end
        n_st       = i_prev;
        n_st.rem_a = w_ta[31:0];
        n_st.rem_b = w_tb[31:0];
        n_st.div_a = {i_prev.div_a[62:0], 1'b0};
        n_st.div_b = {i_prev.div_b[62:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.vld <= 1'b0;
        end else if (i_en) begin
            r_st.vld <= n_st.vld;
        end
        if (i_en) begin
            r_st.ok     <= n_st.ok;
            r_st.tx     <= n_st.tx;
            r_st.rx     <= n_st.rx;
            r_st.common <= n_st.common;
            r_st.rem_a  <= n_st.rem_a;
            r_st.div_a  <= n_st.div_a;
            r_st.rem_b  <= n_st.rem_b;
            r_st.div_b  <= n_st.div_b;
        end
    end

    assign o_next = r_st;

endmodule

@@ rtl/core/tdma_ring_phase_observer_core.sv @@
// ---------------------------------------------------------------------------
// TDMA ring phase observer
// Admits or rejects ring clock observations against the TDMA schedule.
// ---------------------------------------------------------------------------
// Takes one observation per clock cycle unless stalled and gives one result per
// observation in order. 64 remainder cells (one dividend bit each) compute common
// time mod period and (tx phase + link delay) mod period, then one stage forms the
// cycle start and residual and one output register wraps, clamps and adds. A
// stalled output freezes the whole chain. Configuration writes take effect at once;
// the user must make them only while no request is in flight (not enforced).
`include "tdma_ring_phase_observer_core_defines.svh"
module tdma_ring_phase_observer_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [3:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    // observation in
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // observing node id, ref node id, obs checksum, resolution, quality bits,
    // identity present, node count, tx phase, rx phase,
    // path delay, common time, zero pad
    input  logic [231:0] i_s_tdata,
    // result out
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // accepted, wrapped phase residual, window start, receive timestamp, zero pad
    output logic [167:0] o_m_tdata
);
    import trpo_pkg::*;

    // config registers
    logic        r_en;
    logic [31:0] r_period;
    logic [31:0] r_offset;
    logic [31:0] r_width;
    logic [4:0]  r_nodes;
    logic [3:0]  r_local;
    logic [3:0]  r_ref;
    logic [31:0] r_csum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= 1'b0;
            r_period <= '0;
            r_offset <= '0;
            r_width  <= '0;
            r_nodes  <= '0;
            r_local  <= '0;
            r_ref    <= '0;
            r_csum   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SCHEDULE_ENABLED:  r_en     <= i_cfg_data[0];
                REG_PERIOD_NS:         r_period <= i_cfg_data;
                REG_WINDOW_OFFSET_NS:  r_offset <= i_cfg_data;
                REG_WINDOW_WIDTH_NS:   r_width  <= i_cfg_data;
                REG_RING_NODES:        r_nodes  <= i_cfg_data[4:0];
                REG_LOCAL_SLOT:        r_local  <= i_cfg_data[3:0];
                REG_REFERENCE_SLOT:    r_ref    <= i_cfg_data[3:0];
                REG_SCHEDULE_CHECKSUM: r_csum   <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // input field unpack
    logic [3:0]  w_src;
    logic [3:0]  w_refn;
    logic [31:0] w_ocsum;
    logic [15:0] w_res;
    logic [3:0]  w_qb;
    logic        w_ident;
    logic [4:0]  w_cnt;
    logic [31:0] w_tx;
    logic [31:0] w_rx;
    logic [31:0] w_delay;
    logic [63:0] w_common;
    assign w_src    = i_s_tdata[3:0];
    assign w_refn   = i_s_tdata[7:4];
    assign w_ocsum  = i_s_tdata[39:8];
    assign w_res    = i_s_tdata[55:40];
    assign w_qb     = i_s_tdata[59:56];
    assign w_ident  = i_s_tdata[60];
    assign w_cnt    = i_s_tdata[65:61];
    assign w_tx     = i_s_tdata[97:66];
    assign w_rx     = i_s_tdata[129:98];
    assign w_delay  = i_s_tdata[161:130];
    assign w_common = i_s_tdata[225:162];

    // chain advances whenever the output register can move
    logic w_adv;
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    // schedule and field checks other than the modulo ones
    logic   w_sched_ok;
    logic   w_in_ok;
    logic [32:0] w_sum;
    t_stage w_st [0:NUM_CELLS];

    always_comb begin
        w_sched_ok = r_en && (r_period != '0) && (r_csum != '0) && (r_width != '0)
            && (r_offset < r_period) && (r_width <= r_period - r_offset)
            && (r_nodes >= 5'd2) && (r_nodes <= 5'(MAX_NODES))
            && ({1'b0, r_local} < r_nodes) && ({1'b0, r_ref} < r_nodes);
        w_in_ok = (w_cnt == r_nodes) && (w_src == r_local) && (w_refn == r_ref)
            && w_ident && (w_ocsum == r_csum)
            && (w_res != '0) && (w_res <= 16'(RESOLUTION_LIMIT_NS))
            && w_qb[0] && !w_qb[1] && (w_qb[3:2] == 2'b11)
            && (w_tx < r_period) && (w_rx < r_period) && (w_common != '0);
        w_sum = {1'b0, w_tx} + {1'b0, w_delay};
        w_st[0].vld    = i_s_tvalid;
        w_st[0].ok     = w_sched_ok && w_in_ok;
        w_st[0].tx     = w_tx;
        w_st[0].rx     = w_rx;
        w_st[0].common = w_common;
        w_st[0].rem_a  = '0;
        w_st[0].div_a  = w_common;
        w_st[0].rem_b  = '0;
        w_st[0].div_b  = {31'b0, w_sum};
    end

    // remainder chain
    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++) begin : g_cell
            trpo_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (w_adv),
                .i_period (r_period),
                .i_prev   (w_st[g]),
                .o_next   (w_st[g+1])
            );
        end
    endgenerate

    // finish stage: modulo check, cycle start, raw residual
    t_stage      w_last;
    logic        r_f_vld;
    logic        r_f_ok;
    logic [63:0] r_f_cyc;
    logic [31:0] r_f_rx;
    logic signed [33:0] r_f_diff;
    assign w_last = w_st[NUM_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_adv) begin
            r_f_vld <= w_last.vld;
        end
        if (w_adv) begin
            r_f_ok   <= w_last.ok && (w_last.rem_a == w_last.tx)
                        && (w_last.common >= {32'b0, w_last.tx});
            r_f_cyc  <= w_last.common - {32'b0, w_last.tx};
            r_f_rx   <= w_last.rx;
            r_f_diff <= $signed({2'b0, w_last.rx}) - $signed({2'b0, w_last.rem_b});
        end
    end

    // output stage: wrap, clamp, window sums
    logic [64:0]        w_ws;
    logic signed [33:0] w_half;
    logic signed [33:0] w_p;
    logic signed [33:0] w_r;
    logic [31:0]        w_pe;
    logic               w_acc;
    logic [160:0]       n_data;
    logic               r_o_vld;
    logic [160:0]       r_o_data;

    always_comb begin
        w_ws   = {1'b0, r_f_cyc} + {33'b0, r_offset};
        w_p    = $signed({2'b0, r_period});
        w_half = $signed({3'b0, r_period[31:1]});
        w_r    = r_f_diff;
        if (r_f_diff > w_half) begin
            w_r = r_f_diff - w_p;
        end else if (r_f_diff < -w_half) begin
            w_r = r_f_diff + w_p;
        end
        if (w_r > 34'sd2147483647) begin
            w_pe = 32'h7fff_ffff;
        end else if (w_r < -34'sd2147483648) begin
            w_pe = 32'h8000_0000;
        end else begin
            w_pe = w_r[31:0];
        end
        w_acc = r_f_ok && !w_ws[64];
        if (w_acc) begin
            n_data = {r_f_cyc + {32'b0, r_f_rx}, w_ws[63:0], w_pe, 1'b1};
        end else begin
            n_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_o_vld <= r_f_vld;
        end
        if (w_adv) begin
            r_o_data <= n_data;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {7'b0, r_o_data};

    // assertions
    `TRPO_ASSERT(a_reject_zero, o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[160:1] == '0)
    `TRPO_ASSERT(a_ready_rule, o_s_tready == (!o_m_tvalid || i_m_tready))
    `TRPO_ASSERT(a_stall_hold, o_m_tvalid && !i_m_tready |=> $stable(r_f_vld))
    `TRPO_ASSERT_RST(a_reset_idle, !i_rst_n |=> !o_m_tvalid)

endmodule

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// TDMA ring phase observer testbench
// Drives observations against a range of schedules, directed first and then
// random, and checks every result against an in-bench predictor.
// ---------------------------------------------------------------------------
module tb;
    import trpo_pkg::*;

    // quality flag masks
    localparam logic [3:0] QB_DPLL_ELIGIBLE  = 4'b0001;
    localparam logic [3:0] QB_DIAG_ONLY      = 4'b0010;
    localparam logic [3:0] QB_PHASE_AND_TIME = 4'b1100;
    // index outside the register map
    localparam logic [3:0] REG_UNMAPPED      = 4'd9;
    localparam longint unsigned U64_MAX      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int DRAIN_CYCLES              = 80;

    typedef struct packed {
        logic [5:0]  pad;
        logic [63:0] common;
        logic [31:0] delay;
        logic [31:0] rx;
        logic [31:0] tx;
        logic [4:0]  cnt;
        logic        ident;
        logic [3:0]  qb;
        logic [15:0] res;
        logic [31:0] csum;
        logic [3:0]  refn;
        logic [3:0]  src;
    } t_obs;

    typedef struct packed {
        logic [6:0]  pad;
        logic [63:0] observed;
        logic [63:0] wstart;
        logic [31:0] perr;
        logic        acc;
    } t_verdict;

    typedef struct {
        logic        enabled;
        logic [31:0] period;
        logic [31:0] offset;
        logic [31:0] width;
        logic [4:0]  nodes;
        logic [3:0]  local_id;
        logic [3:0]  ref_id;
        logic [31:0] csum;
    } t_sched;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [3:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [231:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [167:0] o_m_tdata;

    t_sched   sched;
    t_verdict pending_verdicts[$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       mismatches = 0;
    int       n_results = 0;
    int       n_admitted = 0;
    int       n_schedules = 0;

    tdma_ring_phase_observer_core dut (.*);

    always #5 i_clk = ~i_clk;

    // admission predictor
    function automatic t_verdict judge(t_obs o);
        t_verdict v;
        bit ok;
        longint unsigned cstart, expd, p;
        longint rr, half;
        v = '0;
        p = {32'b0, sched.period};
        ok = sched.enabled && p != 0 && sched.csum != 0 && sched.width != 0
            && sched.offset < sched.period
            && sched.width <= sched.period - sched.offset
            && sched.nodes >= 2 && sched.nodes <= MAX_NODES
            && sched.local_id < sched.nodes && sched.ref_id < sched.nodes;
        if (ok) begin
            if (o.cnt < 2 || o.cnt > MAX_NODES || o.cnt != sched.nodes) ok = 0;
            else if (o.src != sched.local_id || o.refn != sched.ref_id) ok = 0;
            else if (!o.ident || o.csum != sched.csum) ok = 0;
            else if (o.res == 0 || o.res > RESOLUTION_LIMIT_NS) ok = 0;
            else if ((o.qb & QB_DPLL_ELIGIBLE) == 0 || (o.qb & QB_DIAG_ONLY) != 0
                     || (o.qb & QB_PHASE_AND_TIME) != QB_PHASE_AND_TIME) ok = 0;
            else if (o.tx >= sched.period || o.rx >= sched.period || o.common == 0)
                ok = 0;
            else if (o.common % p != {32'b0, o.tx} || o.common < {32'b0, o.tx}) ok = 0;
        end
        if (ok) begin
            cstart = o.common - o.tx;
            if (U64_MAX - cstart < {32'b0, sched.offset}) ok = 0;
        end
        if (!ok) return v;
        expd = ({32'b0, o.tx} + {32'b0, o.delay}) % p;
        rr = longint'({32'b0, o.rx}) - longint'(expd);
        half = longint'(p) / 2;
        if (rr > half) rr -= longint'(p);
        if (rr < -half) rr += longint'(p);
        if (rr > 64'sd2147483647) rr = 64'sd2147483647;
        if (rr < -64'sd2147483648) rr = -64'sd2147483648;
        v.acc = 1'b1;
        v.perr = rr[31:0];
        v.wstart = cstart + sched.offset;
        v.observed = cstart + o.rx;
        return v;
    endfunction

    // result checker and output stall
    always @(posedge i_clk) begin
        t_verdict got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            n_results++;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_verdicts.pop_front();
                if (got.acc != want.acc || got.perr != want.perr
                    || got.wstart != want.wstart || got.observed != want.observed
                    || got.pad != '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp acc=%0d err=%0d ws=%h ot=%h,",
                                  " got acc=%0d err=%0d ws=%h ot=%h"},
                            want.acc, $signed(want.perr), want.wstart, want.observed,
                            got.acc, $signed(got.perr), got.wstart, got.observed);
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one observation request; valid stays high for a back-to-back follower
    task automatic send_obs(input t_obs o);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= o;
        do @(posedge i_clk); while (!o_s_tready);
        pending_verdicts.push_back(judge(o));
        if (judge(o).acc) n_admitted++;
    endtask

    // hold off until every result is back and the chain is empty
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SCHEDULE_ENABLED:  sched.enabled = val[0];
            REG_PERIOD_NS:         sched.period = val;
            REG_WINDOW_OFFSET_NS:  sched.offset = val;
            REG_WINDOW_WIDTH_NS:   sched.width = val;
            REG_RING_NODES:        sched.nodes = val[4:0];
            REG_LOCAL_SLOT:        sched.local_id = val[3:0];
            REG_REFERENCE_SLOT:    sched.ref_id = val[3:0];
            REG_SCHEDULE_CHECKSUM: sched.csum = val;
            default: ;
        endcase
    endtask

    task automatic load_schedule(input t_sched s);
        drain();
        write_reg(REG_SCHEDULE_ENABLED, {31'b0, s.enabled});
        write_reg(REG_PERIOD_NS, s.period);
        write_reg(REG_WINDOW_OFFSET_NS, s.offset);
        write_reg(REG_WINDOW_WIDTH_NS, s.width);
        write_reg(REG_RING_NODES, {27'b0, s.nodes});
        write_reg(REG_LOCAL_SLOT, {28'b0, s.local_id});
        write_reg(REG_REFERENCE_SLOT, {28'b0, s.ref_id});
        write_reg(REG_SCHEDULE_CHECKSUM, s.csum);
        // an unmapped index must leave everything alone
        write_reg(REG_UNMAPPED, $urandom);
        i_cfg_valid <= 1'b0;
        n_schedules++;
    endtask

    function automatic t_sched rand_schedule(input int kind);
        t_sched s;
        case (kind)
            0: s.period = 32'hFFFF_FFFF;
            1: s.period = 32'd1;
            2: s.period = $urandom;
            default: s.period = $urandom_range(1, 5000);
        endcase
        if (s.period == 0) s.period = 1;
        s.enabled = 1'b1;
        s.offset = $urandom % s.period;
        s.width = 1 + ($urandom % (s.period - s.offset));
        s.nodes = 5'($urandom_range(2, MAX_NODES));
        s.local_id = 4'($urandom % s.nodes);
        s.ref_id = 4'($urandom % s.nodes);
        s.csum = $urandom | 32'h1;
        return s;
    endfunction

    // well-formed observation for the loaded schedule
    function automatic t_obs good_obs(input bit top);
        t_obs o;
        longint unsigned kmax, k, p;
        p = (sched.period == 0) ? 64'd1 : {32'b0, sched.period};
        o.pad = '0;
        o.src = sched.local_id;
        o.refn = sched.ref_id;
        o.csum = sched.csum;
        o.res = 16'($urandom_range(1, RESOLUTION_LIMIT_NS));
        o.qb = QB_DPLL_ELIGIBLE | QB_PHASE_AND_TIME;
        o.ident = 1'b1;
        o.cnt = sched.nodes;
        o.tx = 32'($urandom % p);
        o.rx = 32'($urandom % p);
        o.delay = $urandom;
        kmax = (U64_MAX - o.tx) / p;
        if (top) k = kmax - $urandom_range(0, 1);
        else if (kmax == U64_MAX) k = {$urandom, $urandom};
        else k = {$urandom, $urandom} % (kmax + 1);
        if (k > kmax) k = kmax;
        if (k == 0 && o.tx == 0) k = 1;
        o.common = k * p + o.tx;
        return o;
    endfunction

    // one field broken, or plain noise
    function automatic t_obs broken_obs(input t_obs o);
        case ($urandom_range(11))
            0: o.src = 4'($urandom);
            1: o.refn = 4'($urandom);
            2: o.csum = $urandom_range(1) ? 32'h0 : $urandom;
            3: o.res = $urandom_range(1) ? 16'd0
                       : 16'($urandom_range(RESOLUTION_LIMIT_NS + 1, 65535));
            4: o.qb = 4'($urandom);
            5: o.ident = 1'b0;
            6: o.cnt = 5'($urandom);
            7: o.tx = $urandom_range(1) ? sched.period : $urandom;
            8: o.rx = $urandom_range(1) ? sched.period + $urandom_range(3) : $urandom;
            9: o.common = o.common + $urandom_range(1, 3);
            10: o.common = 64'd0;
            default: o = {6'b0, 226'({$urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom})};
        endcase
        return o;
    endfunction

    task automatic test_reset_schedule();
        t_obs o;
        // all registers zero: nothing can be admitted
        repeat (4) begin
            o = broken_obs(good_obs(0));
            send_obs(o);
        end
    endtask

    task automatic test_directed();
        t_obs   o;
        t_sched s;
        load_schedule(rand_schedule(3));
        send_obs(good_obs(0));
        // eleven single-field faults, one per observation
        for (int f = 0; f < 11; f++) begin
            o = good_obs(0);
            case (f)
                0: o.src = o.src + 4'd1;
                1: o.refn = o.refn + 4'd1;
                2: o.csum = ~o.csum;
                3: o.res = 16'd0;
                4: o.res = 16'(RESOLUTION_LIMIT_NS + 1);
                5: o.qb = o.qb | QB_DIAG_ONLY;
                6: o.qb = QB_PHASE_AND_TIME;
                7: o.ident = 1'b0;
                8: o.cnt = 5'd31;
                9: o.rx = sched.period;
                default: o.common = o.common + 64'd1;
            endcase
            send_obs(o);
        end
        o = good_obs(0);
        o.res = 16'(RESOLUTION_LIMIT_NS);
        o.delay = 32'hFFFF_FFFF;
        o.rx = sched.period - 1;
        send_obs(o);
        // widest period: window start overflow and observed time wrap
        s = rand_schedule(0);
        s.offset = 32'hFFFF_FFFE;
        s.width = 32'd1;
        load_schedule(s);
        repeat (4) send_obs(good_obs(1));
        o = good_obs(0);
        o.tx = 32'hFFFF_FFFE;
        o.rx = 32'd0;
        o.delay = 32'hFFFF_FFFF;
        o.common = {32'b0, o.tx};
        send_obs(o);
        load_schedule(rand_schedule(1));
        send_obs(good_obs(0));
        send_obs(good_obs(1));
    endtask

    task automatic test_bad_schedules();
        t_sched s;
        for (int b = 0; b < 8; b++) begin
            s = rand_schedule(3);
            case (b)
                0: s.enabled = 1'b0;
                1: s.period = 32'd0;
                2: s.csum = 32'd0;
                3: s.width = 32'd0;
                4: s.offset = s.period;
                5: s.nodes = $urandom_range(1) ? 5'd1 : 5'd17;
                6: begin
                    s.nodes = 5'($urandom_range(2, MAX_NODES - 1));
                    s.local_id = s.nodes[3:0];
                end
                default: s.width = s.period - s.offset + 1;
            endcase
            load_schedule(s);
            repeat (3) send_obs(good_obs(0));
        end
    endtask

    task automatic test_random(input int items);
        t_obs o;
        for (int i = 0; i < items; i++) begin
            if (i % 60 == 0) load_schedule(rand_schedule($urandom_range(3)));
            o = good_obs($urandom_range(19) == 0);
            if ($urandom_range(99) < 30) o = broken_obs(o);
            send_obs(o);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sched = '{default: '0};
        test_reset_schedule();
        test_directed();
        test_bad_schedules();
        send_idle_pct = 16;
        recv_stall_pct = 83;
        test_random(250);
        send_idle_pct = 83;
        recv_stall_pct = 16;
        test_random(250);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(250);
        drain();
        $display("covered %0d results, %0d admitted, over %0d schedule loads",
            n_results, n_admitted, n_schedules);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout");
        $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/trpo_pkg.sv
rtl/core/trpo_cell.sv
rtl/core/tdma_ring_phase_observer_core.sv
verif/tb.sv
